// File: hw/rtl/batch_ring_queue_core_macros.svh
// Assertion macros shared by the ring queue checker
`ifndef BATCH_RING_QUEUE_CORE_MACROS_SVH
`define BATCH_RING_QUEUE_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define BRQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle
`define BRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/brq_pkg.sv
// Shared types and constants of the ring queue
package brq_pkg;

  localparam int KIND_W      = 2;
  localparam int ENTRY_PORT_W = 32;
  localparam int REQ_W       = 6;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 9;
  localparam int SIZE_W      = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  typedef enum logic [KIND_W-1:0] {
    K_ENQ    = 2'd0,
    K_DEQ    = 2'd1,
    K_CLOSE  = 2'd2,
    K_REOPEN = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_REFUSED   = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DECODE = 2'd1,
    S_READ   = 2'd2,
    S_LOAD   = 2'd3
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic deq_start;
    logic rd_issue;
    logic rd_load;
  } cmd_t;

  typedef struct packed {
    logic deq_go;
    logic out_free;
    logic more;
  } stat_t;

endpackage

// File: hw/rtl/brq_ram.sv
// Generic single-write, single-read RAM with registered read data
module brq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/brq_ctrl.sv
// Controller state machine of the ring queue
module brq_ctrl
  import brq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (stat.deq_go) begin
          state_nxt = S_READ;
        end else if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (stat.out_free && !stat.more) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DECODE: begin
        cmd.deq_start = stat.deq_go;
        cmd.exec      = !stat.deq_go && stat.out_free;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
      end
      S_LOAD: begin
        cmd.rd_load  = stat.out_free;
        cmd.rd_issue = stat.out_free && stat.more;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/brq_dpath.sv
// Datapath of the ring queue: indices, ring store and result register
module brq_dpath
  import brq_pkg::*;
#(
  parameter int DEPTH       = 256,
  parameter int ENTRY_WIDTH = 32,
  parameter int BATCH_MAX   = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic                    cfg_valid,
  input  logic [SIZE_W-1:0]       cfg_size_log2,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic [ENTRY_PORT_W-1:0] in_entry_in,
  input  logic [REQ_W-1:0]        in_request_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     out_status,
  output logic [ENTRY_PORT_W-1:0] out_entry_out,
  output logic                    out_last,
  output logic [OCC_W-1:0]        out_occupancy
);

  localparam int IW = $clog2(2 * DEPTH);
  localparam int AW = $clog2(DEPTH);
  localparam int DL = $clog2(DEPTH + 1) - 1;
  localparam int SW = (ENTRY_WIDTH < ENTRY_PORT_W) ? ENTRY_WIDTH : ENTRY_PORT_W;
  localparam int CW = (IW > REQ_W + 1) ? IW : REQ_W + 1;
  localparam int NW = $clog2(BATCH_MAX + 1);
  localparam int OW = (IW > OCC_W) ? IW : OCC_W;
  localparam logic [IW-1:0] IDX_MASK = IW'(2 * DEPTH - 1);

  logic [IW-1:0]     wr_idx_r, wr_idx_nxt;
  logic [IW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              closed_r, closed_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [NW-1:0]     cnt_r, cnt_nxt;

  kind_t             kind_r;
  logic [SW-1:0]     entry_r;
  logic [REQ_W-1:0]  req_r;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [ENTRY_PORT_W-1:0] out_entry_r, out_entry_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [OCC_W-1:0]        out_occ_r, out_occ_nxt;

  logic [4:0]    lg;
  logic [IW-1:0] cap;
  logic [IW-1:0] cap_mask;
  logic [IW-1:0] occ_cur;
  logic [IW-1:0] occ_after;
  logic [OW-1:0] occ_cur_ext;
  logic [OW-1:0] occ_after_ext;
  logic [CW-1:0] req_w, occ_w, n_w;
  logic [AW-1:0] wr_slot, rd_slot;
  logic [SW-1:0] rdata;

  logic          enq_ok;
  logic [IW-1:0] exec_wr, exec_rd;
  logic          exec_closed;
  status_t       exec_status;

  // capacity mask and occupancy
  always_comb begin
    lg       = ({1'b0, size_r} > 5'(DL)) ? 5'(DL) : {1'b0, size_r};
    cap      = IW'(1) << lg;
    cap_mask = cap - IW'(1);
    occ_cur  = (wr_idx_r - rd_idx_r) & IDX_MASK;
    wr_slot  = AW'(wr_idx_r & cap_mask);
    rd_slot  = AW'(rd_idx_r & cap_mask);
  end

  // batch length: saturate at BATCH_MAX, then at occupancy
  always_comb begin
    req_w = CW'(req_r);
    occ_w = CW'(occ_cur);
    n_w   = (req_w > CW'(BATCH_MAX)) ? CW'(BATCH_MAX) : req_w;
    if (n_w > occ_w) n_w = occ_w;
  end

  assign stat.deq_go   = (kind_r == K_DEQ) && (n_w != '0);
  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.more     = (cnt_r != '0);

  // single-beat operations
  always_comb begin
    enq_ok      = 1'b0;
    exec_wr     = wr_idx_r;
    exec_rd     = rd_idx_r;
    exec_closed = closed_r;
    exec_status = ST_DONE;
    case (kind_r)
      K_ENQ: begin
        if (closed_r || (occ_cur >= cap)) begin
          exec_status = ST_REFUSED;
        end else begin
          enq_ok  = 1'b1;
          exec_wr = (wr_idx_r + IW'(1)) & IDX_MASK;
        end
      end
      K_DEQ: begin
        exec_status = ST_EMPTY;
      end
      K_CLOSE: begin
        if (occ_cur != '0) begin
          exec_status = ST_NOT_EMPTY;
        end else begin
          exec_closed = 1'b1;
        end
      end
      K_REOPEN: begin
        exec_wr     = '0;
        exec_rd     = '0;
        exec_closed = 1'b0;
      end
      default: begin
        exec_status = ST_DONE;
      end
    endcase
    occ_after = (exec_wr - exec_rd) & IDX_MASK;
  end

  assign occ_cur_ext   = OW'(occ_cur);
  assign occ_after_ext = OW'(occ_after);

  brq_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && enq_ok),
    .waddr (wr_slot),
    .wdata (entry_r),
    .re    (cmd.rd_issue),
    .raddr (rd_slot),
    .rdata (rdata)
  );

  // state updates
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    closed_nxt = closed_r;
    cnt_nxt    = cnt_r;
    if (cmd.exec) begin
      wr_idx_nxt = exec_wr;
      rd_idx_nxt = exec_rd;
      closed_nxt = exec_closed;
    end
    if (cmd.deq_start) begin
      cnt_nxt = n_w[NW-1:0];
    end
    if (cmd.rd_issue) begin
      rd_idx_nxt = (rd_idx_r + IW'(1)) & IDX_MASK;
      cnt_nxt    = cnt_nxt - NW'(1);
    end
  end

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_last_nxt   = out_last_r;
    out_occ_nxt    = out_occ_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.exec) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = exec_status;
      out_entry_nxt  = '0;
      out_last_nxt   = 1'b1;
      out_occ_nxt    = occ_after_ext[OCC_W-1:0];
    end else if (cmd.rd_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_DONE;
      out_entry_nxt  = ENTRY_PORT_W'(rdata);
      out_last_nxt   = (cnt_r == '0);
      out_occ_nxt    = occ_cur_ext[OCC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      closed_r    <= 1'b0;
      size_r      <= SIZE_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      closed_r    <= closed_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) size_r <= cfg_size_log2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= kind_t'(in_kind);
      entry_r <= in_entry_in[SW-1:0];
      req_r   <= in_request_count;
    end
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_last_r   <= out_last_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_entry_out = out_entry_r;
  assign out_last      = out_last_r;
  assign out_occupancy = out_occ_r;

endmodule

// File: hw/rtl/batch_ring_queue_core.sv
// Top level of the ring queue: controller and datapath
// Enqueue, close, reopen and empty dequeue: S_DECODE, then the result register when free.
// Dequeue of n entries: S_DECODE, S_READ, then S_LOAD sends one entry per cycle
// while out_ready holds high, bounded by the registered read of the ring RAM.
// One item is in progress at a time; the result register frees the input side as it drains.
// Reset (synchronous, rst_n low): indices zero, queue open, size_log2 = 8, outputs idle.
// The ring RAM is not cleared and needs no clearing pass.
module batch_ring_queue_core
  import brq_pkg::*;
#(
  parameter int DEPTH       = 256,
  parameter int ENTRY_WIDTH = 32,
  parameter int BATCH_MAX   = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SIZE_W-1:0]       cfg_size_log2,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic [ENTRY_PORT_W-1:0] in_entry_in,
  input  logic [REQ_W-1:0]        in_request_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     out_status,
  output logic [ENTRY_PORT_W-1:0] out_entry_out,
  output logic                    out_last,
  output logic [OCC_W-1:0]        out_occupancy
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  brq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  brq_dpath #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH),
    .BATCH_MAX   (BATCH_MAX)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_valid        (cfg_valid),
    .cfg_size_log2    (cfg_size_log2),
    .in_kind          (in_kind),
    .in_entry_in      (in_entry_in),
    .in_request_count (in_request_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_entry_out    (out_entry_out),
    .out_last         (out_last),
    .out_occupancy    (out_occupancy)
  );

endmodule

// File: hw/rtl/brq_checker.sv
// Port-level assertion checker of the ring queue, bound to the top level
`include "batch_ring_queue_core_macros.svh"

module brq_checker
  import brq_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic [SIZE_W-1:0]       cfg_size_log2,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [KIND_W-1:0]       in_kind,
  input logic [ENTRY_PORT_W-1:0] in_entry_in,
  input logic [REQ_W-1:0]        in_request_count,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [STATUS_W-1:0]     out_status,
  input logic [ENTRY_PORT_W-1:0] out_entry_out,
  input logic                    out_last,
  input logic [OCC_W-1:0]        out_occupancy
);

  `BRQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_entry_out) && $stable(out_last) && $stable(out_occupancy), "result beat changed while stalled")
  `BRQ_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second beat taken while an item is in progress")
  `BRQ_ASSERT_ALWAYS(a_non_entry, !(out_valid && (out_status != ST_DONE)) || (out_last && (out_entry_out == '0)), "non-entry result must be last and carry no entry")
  `BRQ_ASSERT_ALWAYS(a_occ_bound, !out_valid || (int'(out_occupancy) <= DEPTH), "occupancy beyond ring depth")

endmodule

bind batch_ring_queue_core brq_checker #(.DEPTH(DEPTH)) u_brq_checker (.*);

// File: bench/batch_ring_queue_checker.sv
// Checker for the ring queue: tracks the queue state from accepted beats and compares results
`timescale 1ns / 100ps

module batch_ring_queue_checker
  import brq_pkg::*;
#(
  parameter int DEPTH       = 256,
  parameter int ENTRY_WIDTH = 32,
  parameter int BATCH_MAX   = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [SIZE_W-1:0]       cfg_size_log2,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic [ENTRY_PORT_W-1:0] in_entry_in,
  input  logic [REQ_W-1:0]        in_request_count,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [STATUS_W-1:0]     out_status,
  input  logic [ENTRY_PORT_W-1:0] out_entry_out,
  input  logic                    out_last,
  input  logic [OCC_W-1:0]        out_occupancy,
  output int                      fail_count,
  output int                      pending
);

  localparam int DEPTH_LOG2 = $clog2(DEPTH);
  localparam int IDX_W      = DEPTH_LOG2 + 1;
  localparam logic [ENTRY_PORT_W-1:0] ENTRY_MASK = (ENTRY_WIDTH >= ENTRY_PORT_W) ?
    {ENTRY_PORT_W{1'b1}} : ({ENTRY_PORT_W{1'b1}} >> (ENTRY_PORT_W - ENTRY_WIDTH));

  typedef struct {
    status_t                 status;
    logic [ENTRY_PORT_W-1:0] entry;
    logic                    last;
    logic [OCC_W-1:0]        occ;
  } queue_beat_t;

  logic [ENTRY_PORT_W-1:0] ring_words [DEPTH];
  logic [IDX_W-1:0]        wr_ptr;
  logic [IDX_W-1:0]        rd_ptr;
  logic                    enq_closed;
  logic [SIZE_W-1:0]       size_sel;
  queue_beat_t             awaited_beats [$];

  function automatic int ring_capacity();
    int lg;
    lg = (size_sel > DEPTH_LOG2) ? DEPTH_LOG2 : int'(size_sel);
    return 1 << lg;
  endfunction

  function automatic int held();
    logic [IDX_W-1:0] diff;
    diff = wr_ptr - rd_ptr;
    return int'(diff);
  endfunction

  function automatic void push_beat(input status_t st, input logic [ENTRY_PORT_W-1:0] word,
                                    input logic fin);
    queue_beat_t b;
    b.status = st;
    b.entry  = word;
    b.last   = fin;
    b.occ    = OCC_W'(held());
    awaited_beats.push_back(b);
  endfunction

  task automatic predict_item(input logic [KIND_W-1:0] kind, input logic [ENTRY_PORT_W-1:0] word,
                              input logic [REQ_W-1:0] cnt);
    int cap;
    int n;
    logic [ENTRY_PORT_W-1:0] w;
    cap = ring_capacity();
    case (kind_t'(kind))
      K_ENQ: begin
        if (enq_closed || held() >= cap) begin
          push_beat(ST_REFUSED, '0, 1'b1);
        end else begin
          ring_words[int'(wr_ptr) & (cap - 1)] = word & ENTRY_MASK;
          wr_ptr = wr_ptr + 1'b1;
          push_beat(ST_DONE, '0, 1'b1);
        end
      end
      K_DEQ: begin
        n = (int'(cnt) > BATCH_MAX) ? BATCH_MAX : int'(cnt);
        if (n > held()) n = held();
        if (n == 0) push_beat(ST_EMPTY, '0, 1'b1);
        for (int i = 0; i < n; i++) begin
          w = ring_words[int'(rd_ptr) & (cap - 1)];
          rd_ptr = rd_ptr + 1'b1;
          push_beat(ST_DONE, w, i == n - 1);
        end
      end
      K_CLOSE: begin
        if (held() != 0) begin
          push_beat(ST_NOT_EMPTY, '0, 1'b1);
        end else begin
          enq_closed = 1'b1;
          push_beat(ST_DONE, '0, 1'b1);
        end
      end
      default: begin
        wr_ptr     = '0;
        rd_ptr     = '0;
        enq_closed = 1'b0;
        push_beat(ST_DONE, '0, 1'b1);
      end
    endcase
  endtask

  function automatic void compare_field(input string field_name,
                                        input logic [ENTRY_PORT_W-1:0] want,
                                        input logic [ENTRY_PORT_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field_name, want, got);
    end
  endfunction

  task automatic check_beat();
    queue_beat_t want;
    if (awaited_beats.size() == 0) begin
      fail_count++;
      $display("%0t: result beat with nothing awaited, expected none actual status %0d entry %h",
               $time, out_status, out_entry_out);
    end else begin
      want = awaited_beats.pop_front();
      compare_field("status", ENTRY_PORT_W'(want.status), ENTRY_PORT_W'(out_status));
      compare_field("entry", want.entry, out_entry_out);
      compare_field("last", ENTRY_PORT_W'(want.last), ENTRY_PORT_W'(out_last));
      compare_field("occupancy", ENTRY_PORT_W'(want.occ), ENTRY_PORT_W'(out_occupancy));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr     = '0;
      rd_ptr     = '0;
      enq_closed = 1'b0;
      size_sel   = SIZE_RESET;
      fail_count = 0;
      awaited_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) size_sel = cfg_size_log2;
      if (out_valid && out_ready) check_beat();
      if (in_valid && in_ready) predict_item(in_kind, in_entry_in, in_request_count);
    end
    pending = awaited_beats.size();
  end

endmodule

// File: bench/batch_ring_queue_core_test.sv
// Top of the ring queue bench: clock, reset, stimulus, result sink, watchdog and verdict
`timescale 1ns / 100ps

module batch_ring_queue_core_test;
  import brq_pkg::*;

  localparam int RANDOM_ITEMS    = 216;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 4000;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [SIZE_W-1:0]       cfg_size_log2;
  logic                    in_valid;
  logic                    in_ready;
  logic [KIND_W-1:0]       in_kind;
  logic [ENTRY_PORT_W-1:0] in_entry_in;
  logic [REQ_W-1:0]        in_request_count;
  logic                    out_valid;
  logic                    out_ready;
  logic [STATUS_W-1:0]     out_status;
  logic [ENTRY_PORT_W-1:0] out_entry_out;
  logic                    out_last;
  logic [OCC_W-1:0]        out_occupancy;

  int fail_total;
  int pending_beats;
  int holdoffs_wanted = 0;
  int holdoffs_done = 0;
  int stall_cycles = 0;
  bit calm = 1'b0;

  always #5 clk = ~clk;

  batch_ring_queue_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_size_log2    (cfg_size_log2),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_entry_in      (in_entry_in),
    .in_request_count (in_request_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_entry_out    (out_entry_out),
    .out_last         (out_last),
    .out_occupancy    (out_occupancy)
  );

  batch_ring_queue_checker queue_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_size_log2    (cfg_size_log2),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_entry_in      (in_entry_in),
    .in_request_count (in_request_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_entry_out    (out_entry_out),
    .out_last         (out_last),
    .out_occupancy    (out_occupancy),
    .fail_count       (fail_total),
    .pending          (pending_beats)
  );

  task automatic send_item(input kind_t k, input logic [ENTRY_PORT_W-1:0] word,
                           input logic [REQ_W-1:0] cnt);
    if (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= k;
    in_entry_in      <= word;
    in_request_count <= cnt;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_beats != 0);
    @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] lg);
    cfg_valid     <= 1'b1;
    cfg_size_log2 <= lg;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && holdoffs_done < holdoffs_wanted) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        holdoffs_done++;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 7);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int pick;
    kind_t k;
    logic [REQ_W-1:0] cnt;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_kind          <= K_ENQ;
    in_entry_in      <= '0;
    in_request_count <= '0;
    cfg_valid        <= 1'b0;
    cfg_size_log2    <= SIZE_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill a 32-entry ring, the sink holding off at first, then drain in one full batch
    write_size(SIZE_W'(5));
    holdoffs_wanted = 1;
    for (int i = 0; i < 33; i++) send_item(K_ENQ, $urandom, REQ_W'($urandom_range(0, 63)));
    send_item(K_DEQ, $urandom, REQ_W'($urandom_range(32, 63)));
    wait_drained();

    send_item(K_DEQ, '0, '0);
    send_item(K_DEQ, '0, REQ_W'(7));
    send_item(K_ENQ, '0, '0);
    send_item(K_ENQ, '1, '1);
    send_item(K_ENQ, $urandom, '0);
    send_item(K_CLOSE, '0, '0);
    send_item(K_DEQ, '1, '1);
    send_item(K_CLOSE, '0, '0);
    send_item(K_CLOSE, '1, '0);
    send_item(K_ENQ, $urandom, '0);
    send_item(K_REOPEN, '0, '0);
    wait_drained();
    write_size(SIZE_W'(2));
    for (int i = 0; i < 5; i++) send_item(K_ENQ, $urandom, '0);
    wait_drained();
    // shrink while holding more than the new capacity
    write_size(SIZE_W'(1));
    send_item(K_ENQ, $urandom, '0);
    send_item(K_DEQ, '0, REQ_W'(1));
    wait_drained();
    write_size(SIZE_W'(15));
    send_item(K_ENQ, $urandom, '0);
    send_item(K_DEQ, '0, REQ_W'(32));
    wait_drained();
    write_size('0);
    send_item(K_ENQ, $urandom, '0);
    send_item(K_ENQ, $urandom, '0);
    send_item(K_DEQ, '0, REQ_W'(1));
    send_item(K_REOPEN, $urandom, '1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        // empty the ring so the new size never addresses a stale slot
        send_item(K_REOPEN, '0, '0);
        wait_drained();
        write_size(($urandom_range(99) < 60) ? SIZE_W'($urandom_range(0, 4)) :
                                               SIZE_W'($urandom_range(0, 15)));
      end
      if (n == 200) wait_drained();
      calm = (n >= 100 && n < 170);
      pick = $urandom_range(99);
      if (pick < 50) k = K_ENQ;
      else if (pick < 85) k = K_DEQ;
      else if (pick < 92) k = K_CLOSE;
      else k = K_REOPEN;
      cnt = ($urandom_range(99) < 80) ? REQ_W'($urandom_range(0, 8)) :
                                        REQ_W'($urandom_range(0, 63));
      send_item(k, $urandom, cnt);
    end
    calm = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_total == 0 && pending_beats == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
